// ===== rtl/lzwe_pkg.sv =====
// Shared types and constants of the LZW byte stream encoder.
// No dependencies.
package lzwe_pkg;
  localparam logic [8:0] CODE_CLEAR  = 9'd256;
  localparam logic [8:0] CODE_END    = 9'd257;
  localparam logic [8:0] CODE_FIRST  = 9'd258;
  localparam logic [4:0] START_WIDTH = 5'd9;
  localparam logic [3:0] CFG_RESET   = 4'd12;
  localparam int         CODE_BUS_W  = 16;
  localparam int         EPOCH_W     = 4;
  localparam int         ACC_W       = 24;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } lzwe_item_t;

  typedef struct packed {
    logic [CODE_BUS_W-1:0] code;
    logic [4:0]            width;
    logic                  step_final;
    logic                  stream_fin;
  } lzwe_code_t;
endpackage

// ===== rtl/lzwe_if.sv =====
// Request channel interfaces of the LZW encoder: input bytes and packed bytes.
// Depends on nothing.
interface lzwe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;
  modport source (output valid, in_byte, last_byte, input ready);
  modport sink (input valid, in_byte, last_byte, output ready);
endinterface

interface lzwe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       stream_end;
  modport source (output valid, out_byte, run_last, stream_end, input ready);
  modport sink (input valid, out_byte, run_last, stream_end, output ready);
endinterface

// ===== rtl/lzwe_ram.sv =====
// Generic single write, single read RAM with registered read data.
// No dependencies.
module lzwe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/lzwe_front.sv =====
// Front end: accepts input requests into a two-entry queue.
// Depends on lzwe_pkg and lzwe_if.
module lzwe_front
  import lzwe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  lzwe_in_if.sink    in_ch,
  output logic       item_vld,
  output lzwe_item_t item,
  input  logic       item_pop
);
  lzwe_item_t q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign item_vld    = (cnt_r != 2'd0);
  assign item        = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= '{data: in_ch.in_byte, last: in_ch.last_byte};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (item_pop && item_vld) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(item_pop && item_vld);
    end
  end
endmodule

// ===== rtl/lzwe_packer.sv =====
// Bit packer: appends codes MSB first and drains whole bytes through an
// output register; pads the tail at stream end. Depends on lzwe_pkg, lzwe_if.
module lzwe_packer
  import lzwe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       code_vld,
  input  lzwe_code_t code_req,
  output logic       code_rdy,
  lzwe_out_if.source out_ch
);
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [4:0]       pend_r, pend_nxt;
  logic             busy_r, busy_nxt;
  logic             fin_r, fin_nxt, end_r, end_nxt;
  logic             ov_r, ov_nxt;
  logic [7:0]       ob_r, ob_nxt;
  logic             rl_r, rl_nxt, se_r, se_nxt;
  logic             slot_free;
  logic [4:0]       rem;
  logic [ACC_W-1:0] cmask, shifted;

  assign code_rdy          = !busy_r;
  assign slot_free         = !ov_r || out_ch.ready;
  assign out_ch.valid      = ov_r;
  assign out_ch.out_byte   = ob_r;
  assign out_ch.run_last   = rl_r;
  assign out_ch.stream_end = se_r;
  assign rem               = pend_r - 5'd8;

  always_comb begin
    acc_nxt  = acc_r;
    pend_nxt = pend_r;
    busy_nxt = busy_r;
    fin_nxt  = fin_r;
    end_nxt  = end_r;
    ov_nxt   = ov_r && !out_ch.ready;
    ob_nxt   = ob_r;
    rl_nxt   = rl_r;
    se_nxt   = se_r;
    cmask    = (ACC_W'(1) << code_req.width) - ACC_W'(1);
    shifted  = acc_r >> rem;
    if (!busy_r) begin
      if (code_vld) begin
        acc_nxt  = (acc_r << code_req.width) | (ACC_W'(code_req.code) & cmask);
        pend_nxt = pend_r + code_req.width;
        busy_nxt = 1'b1;
        fin_nxt  = code_req.step_final;
        end_nxt  = code_req.stream_fin;
      end
    end else if (pend_r >= 5'd8) begin
      if (slot_free) begin
        ov_nxt   = 1'b1;
        ob_nxt   = shifted[7:0];
        rl_nxt   = fin_r && (rem < 5'd8) && !(end_r && rem != 5'd0);
        se_nxt   = end_r && rem == 5'd0;
        pend_nxt = rem;
        acc_nxt  = acc_r & ((ACC_W'(1) << rem) - ACC_W'(1));
      end
    end else if (end_r && pend_r != 5'd0) begin
      if (slot_free) begin
        ov_nxt   = 1'b1;
        ob_nxt   = 8'(acc_r << (5'd8 - pend_r));
        rl_nxt   = 1'b1;
        se_nxt   = 1'b1;
        pend_nxt = 5'd0;
        acc_nxt  = '0;
        busy_nxt = 1'b0;
      end
    end else begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    ob_r  <= ob_nxt;
    rl_r  <= rl_nxt;
    se_r  <= se_nxt;
    fin_r <= fin_nxt;
    end_r <= end_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_pend: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> pend_r < 5'd8) else $error("packer idle with whole byte pending");
  a_end_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && se_r) |-> rl_r) else $error("stream end byte not last of its request");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ch.ready) |=> (ov_r && $stable(ob_r))) else $error("output byte lost");
`endif
endmodule

// ===== rtl/lzwe_back.sv =====
// Back end: dictionary lookup and update, width growth, clear and end codes.
// Depends on lzwe_pkg and lzwe_ram.
module lzwe_back
  import lzwe_pkg::*;
#(
  parameter int MAX_W = 12
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [3:0] max_code_width,
  input  logic       item_vld,
  input  lzwe_item_t item,
  output logic       item_pop,
  output logic       code_vld,
  output lzwe_code_t code_req,
  input  logic       code_rdy
);
  localparam int DEPTH = 256 << MAX_W;
  localparam int AW    = MAX_W + 8;
  localparam int EW    = MAX_W + EPOCH_W;

  localparam logic [3:0] ST_CLR   = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_FIRST = 4'd2;
  localparam logic [3:0] ST_LOOK  = 4'd3;
  localparam logic [3:0] ST_MISS  = 4'd4;
  localparam logic [3:0] ST_GROW  = 4'd5;
  localparam logic [3:0] ST_LASTP = 4'd6;
  localparam logic [3:0] ST_LASTE = 4'd7;

  logic [3:0]         state_r, state_nxt;
  logic [7:0]         byte_r, byte_nxt;
  logic               last_r, last_nxt;
  logic [MAX_W-1:0]   prefix_r, prefix_nxt;
  logic [MAX_W:0]     nf_r, nf_nxt;
  logic [4:0]         cw_r, cw_nxt;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic               started_r, started_nxt;
  logic               need_clr_r, need_clr_nxt;
  logic [AW-1:0]      clr_addr_r, clr_addr_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  logic [4:0]    limit;
  logic [MAX_W:0] pow;
  logic          at_pow, ovf, hit;

  lzwe_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_dict (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  assign limit  = (max_code_width < 4'd9 || 5'(max_code_width) > 5'(MAX_W)) ?
                  5'(MAX_W) : 5'(max_code_width);
  assign pow    = (MAX_W+1)'(1) << cw_r;
  assign at_pow = (nf_r == pow);
  assign ovf    = at_pow && (6'(cw_r) + 6'd1 > 6'(limit));
  assign hit    = (rdata[MAX_W-1:0] != '0) && (rdata[EW-1:MAX_W] == epoch_r);
  assign raddr  = {prefix_r, item.data};

  always_comb begin
    state_nxt    = state_r;
    byte_nxt     = byte_r;
    last_nxt     = last_r;
    prefix_nxt   = prefix_r;
    nf_nxt       = nf_r;
    cw_nxt       = cw_r;
    epoch_nxt    = epoch_r;
    started_nxt  = started_r;
    need_clr_nxt = need_clr_r;
    clr_addr_nxt = clr_addr_r;
    item_pop     = 1'b0;
    we           = 1'b0;
    waddr        = {prefix_r, byte_r};
    wdata        = {epoch_r, nf_r[MAX_W-1:0]};
    code_vld     = 1'b0;
    code_req     = '{code: CODE_BUS_W'(prefix_r), width: cw_r,
                     step_final: 1'b0, stream_fin: 1'b0};
    unique case (state_r)
      ST_CLR: begin
        we           = 1'b1;
        waddr        = clr_addr_r;
        wdata        = '0;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == '1) begin
          need_clr_nxt = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (need_clr_r) begin
          state_nxt = ST_CLR;
        end else if (item_vld) begin
          item_pop  = 1'b1;
          byte_nxt  = item.data;
          last_nxt  = item.last;
          state_nxt = started_r ? ST_LOOK : ST_FIRST;
        end
      end
      ST_FIRST: begin
        code_vld = 1'b1;
        code_req = '{code: CODE_BUS_W'(CODE_CLEAR), width: cw_r,
                     step_final: !last_r, stream_fin: 1'b0};
        if (code_rdy) begin
          prefix_nxt  = MAX_W'(byte_r);
          started_nxt = 1'b1;
          state_nxt   = last_r ? ST_LASTP : ST_IDLE;
        end
      end
      ST_LOOK: begin
        if (hit) begin
          prefix_nxt = rdata[MAX_W-1:0];
          state_nxt  = ST_GROW;
        end else begin
          we        = 1'b1;
          nf_nxt    = nf_r + (MAX_W+1)'(1);
          state_nxt = ST_MISS;
        end
      end
      ST_MISS: begin
        code_vld = 1'b1;
        code_req.step_final = !last_r && !ovf;
        if (code_rdy) begin
          prefix_nxt = MAX_W'(byte_r);
          state_nxt  = ST_GROW;
        end
      end
      ST_GROW: begin
        if (ovf) begin
          code_vld = 1'b1;
          code_req = '{code: CODE_BUS_W'(CODE_CLEAR), width: cw_r,
                       step_final: !last_r, stream_fin: 1'b0};
          if (code_rdy) begin
            nf_nxt    = (MAX_W+1)'(CODE_FIRST);
            cw_nxt    = START_WIDTH;
            epoch_nxt = epoch_r + EPOCH_W'(1);
            if (epoch_r == '1) need_clr_nxt = 1'b1;
            state_nxt = last_r ? ST_LASTP : ST_IDLE;
          end
        end else begin
          if (at_pow) cw_nxt = cw_r + 5'd1;
          state_nxt = last_r ? ST_LASTP : ST_IDLE;
        end
      end
      ST_LASTP: begin
        code_vld = 1'b1;
        if (code_rdy) state_nxt = ST_LASTE;
      end
      ST_LASTE: begin
        code_vld = 1'b1;
        code_req = '{code: CODE_BUS_W'(CODE_END), width: cw_r,
                     step_final: 1'b1, stream_fin: 1'b1};
        if (code_rdy) begin
          nf_nxt      = (MAX_W+1)'(CODE_FIRST);
          cw_nxt      = START_WIDTH;
          prefix_nxt  = '0;
          started_nxt = 1'b0;
          epoch_nxt   = epoch_r + EPOCH_W'(1);
          if (epoch_r == '1) need_clr_nxt = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLR;
      prefix_r   <= '0;
      nf_r       <= (MAX_W+1)'(CODE_FIRST);
      cw_r       <= START_WIDTH;
      epoch_r    <= '0;
      started_r  <= 1'b0;
      need_clr_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      prefix_r   <= prefix_nxt;
      nf_r       <= nf_nxt;
      cw_r       <= cw_nxt;
      epoch_r    <= epoch_nxt;
      started_r  <= started_nxt;
      need_clr_r <= need_clr_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_width: assert property (@(posedge clk) disable iff (!rst_n)
    cw_r >= START_WIDTH && cw_r <= 5'(MAX_W)) else $error("code width out of range");
  a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (MAX_W+1)'(prefix_r) < nf_r) else $error("prefix beyond next free code");
  a_nf: assert property (@(posedge clk) disable iff (!rst_n)
    nf_r <= pow) else $error("next free code passed width boundary");
  a_noclr_pop: assert property (@(posedge clk) disable iff (!rst_n)
    item_pop |-> !need_clr_r) else $error("request taken before dictionary clear");
`endif
endmodule

// ===== rtl/lzw_byte_stream_encoder.sv =====
// LZW byte stream encoder, top level: front queue, dictionary engine, packer.
// Depends on lzwe_pkg, lzwe_if, lzwe_front, lzwe_back, lzwe_packer.
//
// Takes one uncompressed byte per request and returns packed LZW codes, MSB
// first, with a clear code at stream start and an end code plus zero padding
// after the byte marked last. A byte that hits the dictionary goes through
// queue pop, synchronous read of the dictionary RAM and update; a miss adds a
// step after the read that hands the prefix code to the packer. The packer
// takes a code only when idle and is then busy while it drains one or two
// bytes and for one more step after them, so a clear or end code that
// follows another code waits until it is idle again, and a stalled output
// holds everything back. The dictionary holds 256 << MAX_CODE_WIDTH entries
// tagged with a 4-bit epoch; after reset, and after every sixteenth dictionary
// restart, a pass clearing all entries runs, during which no byte is taken.
module lzw_byte_stream_encoder
  import lzwe_pkg::*;
#(
  parameter int MAX_CODE_WIDTH = 12
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [3:0] cfg_data,
  lzwe_in_if.sink    in_ch,
  lzwe_out_if.source out_ch
);
  logic [3:0] cfg_r;
  logic       item_vld, item_pop, code_vld, code_rdy;
  lzwe_item_t item;
  lzwe_code_t code_req;

  always_ff @(posedge clk) begin
    if (!rst_n) cfg_r <= CFG_RESET;
    else if (cfg_we) cfg_r <= cfg_data;
  end

  lzwe_front u_front (
    .clk, .rst_n, .in_ch, .item_vld, .item, .item_pop
  );

  lzwe_back #(.MAX_W(MAX_CODE_WIDTH)) u_back (
    .clk, .rst_n, .max_code_width(cfg_r), .item_vld, .item, .item_pop,
    .code_vld, .code_req, .code_rdy
  );

  lzwe_packer u_packer (
    .clk, .rst_n, .code_vld, .code_req, .code_rdy, .out_ch
  );
endmodule
